// File: design/bitmap_frame_allocator_core_macros.svh
// Assertion macros shared by the checking code of the frame allocator.
`ifndef BITMAP_FRAME_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_CORE_MACROS_SVH

// Property checked at every clock edge once reset has been released.
`define BFA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define BFA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: design/bfa_pkg.sv
package bfa_pkg;

  localparam int unsigned MaxFramesDefault = 4096;
  localparam int unsigned WordBits   = 32;
  localparam int unsigned BitSelW    = 5;
  localparam int unsigned FrameW     = 13;
  localparam int unsigned CountW     = 13;
  localparam int unsigned FrameShift = 12;
  localparam logic [CountW-1:0] CountMax   = '1;
  localparam logic [FrameW-1:0] TotalReset = 13'd4096;

  typedef enum logic [2:0] {
    KIND_BEGIN   = 3'd0,
    KIND_RELEASE = 3'd1,
    KIND_RESERVE = 3'd2,
    KIND_FINISH  = 3'd3,
    KIND_ALLOC   = 3'd4,
    KIND_FREE    = 3'd5,
    KIND_QUERY   = 3'd6,
    KIND_NOP     = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_NOT_READY = 3'd1,
    STS_BAD_ADDR  = 3'd2,
    STS_NOT_ALLOC = 3'd3,
    STS_NO_MEM    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MOD,
    B_READ,
    B_CHECK,
    B_DONE
  } back_state_e;

  // Classified command. For free and query, first holds the frame number.
  typedef struct packed {
    kind_e             kind;
    logic [FrameW-1:0] first;
    logic [FrameW-1:0] last;
    logic              skip;
    logic              beyond;
    logic              misaligned;
  } cmd_t;

  // Counter increment that sticks at the top value.
  function automatic logic [CountW-1:0] sat_add(logic [CountW-1:0] a, logic [BitSelW:0] k);
    logic [CountW:0] s;
    s = {1'b0, a} + (CountW+1)'(k);
    return s[CountW] ? CountMax : s[CountW-1:0];
  endfunction

  // Counter decrement that sticks at zero.
  function automatic logic [CountW-1:0] sat_sub(logic [CountW-1:0] a, logic [BitSelW:0] k);
    logic [CountW-1:0] kk;
    kk = CountW'(k);
    return (a > kk) ? (a - kk) : '0;
  endfunction

endpackage

// File: design/bitmap_frame_allocator_core.sv
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    kind_i, address_i, range_length_i
// out       output     out_valid_o / out_ready_i  status_o, frame_address_o, is_used_o,
//                                                 free_count_o, used_count_o
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_data_i (total_frames)
//
// Begin, finish and the failing cases go from the idle state straight to the done state;
// a query of a tracked frame, a free or a range passes through a read and a check state for
// each bitmap word touched, as each word is read from the bitmap memory and then written back.
// Allocate reads and checks each word scanned in the same way, up to words+1 words, and first
// runs a modulo state when the search pointer lies beyond the tracked count and is reduced bit by bit.
// Reset clears control state at once; begin invalidates every bitmap row together.
// A two-item queue lets the input side accept up to two items while a result waits.
module bitmap_frame_allocator_core #(
  parameter int unsigned MAX_FRAMES = bfa_pkg::MaxFramesDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [2:0]                 kind_i,
  input  logic [31:0]                address_i,
  input  logic [32:0]                range_length_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [2:0]                 status_o,
  output logic [31:0]                frame_address_o,
  output logic                       is_used_o,
  output logic [bfa_pkg::CountW-1:0] free_count_o,
  output logic [bfa_pkg::CountW-1:0] used_count_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bfa_pkg::FrameW-1:0] cfg_data_i
);
  import bfa_pkg::*;

  logic [FrameW-1:0] total_q, tot;
  logic              q_full, q_push, q_valid, q_pop;
  cmd_t              cmd_front, cmd_back;

  // Frame count register and its clamp to the map size.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TotalReset;
    end else if (cfg_valid_i) begin
      total_q <= cfg_data_i;
    end
  end
  assign tot = (32'(total_q) > MAX_FRAMES) ? FrameW'(MAX_FRAMES) : total_q;

  bfa_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .address_i     (address_i),
    .range_length_i(range_length_i),
    .tot_i         (tot),
    .q_full_i      (q_full),
    .push_o        (q_push),
    .cmd_o         (cmd_front)
  );

  bfa_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (cmd_front),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (cmd_back)
  );

  bfa_back #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tot_i          (tot),
    .cmd_valid_i    (q_valid),
    .cmd_i          (cmd_back),
    .cmd_pop_o      (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .frame_address_o(frame_address_o),
    .is_used_o      (is_used_o),
    .free_count_o   (free_count_o),
    .used_count_o   (used_count_o)
  );

endmodule

// File: design/bfa_queue.sv
module bfa_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bfa_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output bfa_pkg::cmd_t data_o
);
  import bfa_pkg::*;

  cmd_t       entry_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] count_q, count_d;

  // Pointer and fill bookkeeping.
  always_comb begin
    wptr_d  = wptr_q ^ push_i;
    rptr_d  = rptr_q ^ pop_i;
    count_d = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= data_i;
    end
  end

  assign full_o  = count_q[1];
  assign valid_o = (count_q != 2'd0);
  assign data_o  = entry_q[rptr_q];

endmodule

// File: design/bfa_front.sv
module bfa_front (
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [2:0]                 kind_i,
  input  logic [31:0]                address_i,
  input  logic [32:0]                range_length_i,
  input  logic [bfa_pkg::FrameW-1:0] tot_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output bfa_pkg::cmd_t              cmd_o
);
  import bfa_pkg::*;

  localparam int unsigned SumW = 35;
  localparam int unsigned PageW = SumW - FrameShift;
  localparam logic [SumW-1:0] PageRound = SumW'((1 << FrameShift) - 1);

  logic [SumW-1:0]  addr_w, end_w;
  logic [PageW-1:0] first, last, last_c, tot_w, frame_no;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Range rounding, clamping and address checks.
  always_comb begin
    addr_w   = SumW'(address_i);
    end_w    = addr_w + SumW'(range_length_i);
    tot_w    = PageW'(tot_i);
    frame_no = PageW'(address_i >> FrameShift);
    if (kind_e'(kind_i) == KIND_RELEASE) begin
      first = PageW'((addr_w + PageRound) >> FrameShift);
      last  = PageW'(end_w >> FrameShift);
    end else begin
      first = PageW'(addr_w >> FrameShift);
      last  = PageW'((end_w + PageRound) >> FrameShift);
    end
    last_c = (last > tot_w) ? tot_w : last;

    cmd_o.kind       = kind_e'(kind_i);
    cmd_o.skip       = (first >= tot_w) || (first >= last_c);
    cmd_o.last       = FrameW'(last_c);
    cmd_o.beyond     = (frame_no >= tot_w);
    cmd_o.misaligned = |address_i[FrameShift-1:0];
    if (kind_e'(kind_i) == KIND_RELEASE || kind_e'(kind_i) == KIND_RESERVE) begin
      cmd_o.first = FrameW'(first);
    end else begin
      cmd_o.first = FrameW'(frame_no);
    end
  end

endmodule

// File: design/bfa_back.sv
module bfa_back #(
  parameter int unsigned MAX_FRAMES = bfa_pkg::MaxFramesDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [bfa_pkg::FrameW-1:0] tot_i,
  input  logic                       cmd_valid_i,
  input  bfa_pkg::cmd_t              cmd_i,
  output logic                       cmd_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [2:0]                 status_o,
  output logic [31:0]                frame_address_o,
  output logic                       is_used_o,
  output logic [bfa_pkg::CountW-1:0] free_count_o,
  output logic [bfa_pkg::CountW-1:0] used_count_o
);
  import bfa_pkg::*;

  localparam int unsigned TrackMax = (MAX_FRAMES < 8191) ? MAX_FRAMES : 8191;
  localparam int unsigned MapWords = (TrackMax + WordBits - 1) / WordBits;
  localparam int unsigned AddrW    = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int unsigned VisitW   = AddrW + 1;
  localparam int unsigned DivW     = $clog2(FrameW);

  // Bitmaps; a row that was not written since begin reads as its reset value.
  logic [WordBits-1:0] used_mem  [MapWords];
  logic [WordBits-1:0] owned_mem [MapWords];
  logic [MapWords-1:0] row_valid_q;
  logic [WordBits-1:0] used_rd_q, owned_rd_q;
  logic                rd_valid_q;

  back_state_e       state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [AddrW-1:0]  word_q, word_d;
  logic [VisitW-1:0] visit_q, visit_d;
  logic [BitSelW-1:0] sbit_q, sbit_d;
  logic [FrameW-1:0] rem_q, rem_d;
  logic [DivW-1:0]   div_q, div_d;
  logic [CountW-1:0] free_q, free_d, used_q, used_d;
  logic [FrameW-1:0] ptr_q, ptr_d;
  logic              ready_q, ready_d;
  status_e           res_status_q, res_status_d;
  logic [31:0]       res_addr_q, res_addr_d;
  logic              res_used_q, res_used_d;
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q;
  logic [31:0]       out_addr_q;
  logic              out_used_q;
  logic [CountW-1:0] out_free_q, out_usedc_q;

  logic                rd_en, wr_en, clear_rows, load_out;
  logic [WordBits-1:0] wr_used, wr_owned;

  // Datapath of the word under inspection.
  logic [WordBits-1:0] used_w, owned_w, track_mask, alloc_mask, free_bits;
  logic [WordBits-1:0] range_mask, bit_sel;
  logic [FrameW-1:0]   word_ext, tot_word, lastm1, cand, mod_t;
  logic [VisitW-1:0]   nw;
  logic [BitSelW-1:0]  lo_bit, hi_bit, idx;
  logic                found, last_range_word;
  logic [BitSelW:0]    cnt_rel, cnt_res;

  always_comb begin
    used_w   = rd_valid_q ? used_rd_q : '1;
    owned_w  = rd_valid_q ? owned_rd_q : '0;
    word_ext = FrameW'(word_q);
    tot_word = tot_i >> BitSelW;
    nw       = VisitW'((tot_i + FrameW'(WordBits - 1)) >> BitSelW);
    if (word_ext < tot_word) begin
      track_mask = '1;
    end else if (word_ext == tot_word) begin
      track_mask = ~({WordBits{1'b1}} << tot_i[BitSelW-1:0]);
    end else begin
      track_mask = '0;
    end
    alloc_mask = track_mask;
    if (visit_q == '0) begin
      alloc_mask = alloc_mask & ({WordBits{1'b1}} << sbit_q);
    end
    if (visit_q == nw) begin
      alloc_mask = alloc_mask & ~({WordBits{1'b1}} << sbit_q);
    end
    free_bits = ~used_w & alloc_mask;
    found     = |free_bits;
    idx       = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        idx = BitSelW'(i);
      end
    end
    cand = (word_ext << BitSelW) | FrameW'(idx);

    lastm1 = cmd_q.last - FrameW'(1);
    lo_bit = ((cmd_q.first >> BitSelW) == word_ext) ? cmd_q.first[BitSelW-1:0] : '0;
    last_range_word = ((lastm1 >> BitSelW) == word_ext);
    hi_bit = last_range_word ? lastm1[BitSelW-1:0] : BitSelW'(WordBits - 1);
    range_mask = ({WordBits{1'b1}} << lo_bit)
               & ({WordBits{1'b1}} >> (BitSelW'(WordBits - 1) - hi_bit));
    cnt_rel = (BitSelW+1)'($countones(used_w & range_mask));
    cnt_res = (BitSelW+1)'($countones(~used_w & range_mask));
    bit_sel = {{(WordBits-1){1'b0}}, 1'b1} << cmd_q.first[BitSelW-1:0];

    mod_t = {rem_q[FrameW-2:0], ptr_q[div_q]};
    if (mod_t >= tot_i) begin
      mod_t = mod_t - tot_i;
    end
  end

  // Next state and register updates.
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    word_d       = word_q;
    visit_d      = visit_q;
    sbit_d       = sbit_q;
    rem_d        = rem_q;
    div_d        = div_q;
    free_d       = free_q;
    used_d       = used_q;
    ptr_d        = ptr_q;
    ready_d      = ready_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    res_used_d   = res_used_q;
    unique case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d        = cmd_i;
          res_status_d = STS_OK;
          res_addr_d   = '0;
          res_used_d   = 1'b0;
          word_d       = AddrW'(cmd_i.first >> BitSelW);
          state_d      = B_DONE;
          unique case (cmd_i.kind)
            KIND_BEGIN: begin
              free_d  = '0;
              used_d  = CountW'(tot_i);
              ptr_d   = '0;
              ready_d = 1'b0;
            end
            KIND_RELEASE, KIND_RESERVE: begin
              if (!cmd_i.skip) begin
                state_d = B_READ;
              end
            end
            KIND_FINISH: begin
              ready_d = (free_q != '0);
              if (free_q == '0) begin
                res_status_d = STS_NO_MEM;
              end
            end
            KIND_ALLOC: begin
              visit_d = '0;
              if (!ready_q) begin
                res_status_d = STS_NOT_READY;
              end else if (tot_i == '0) begin
                res_status_d = STS_NO_MEM;
              end else if (ptr_q >= tot_i) begin
                rem_d   = '0;
                div_d   = DivW'(FrameW - 1);
                state_d = B_MOD;
              end else begin
                word_d  = AddrW'(ptr_q >> BitSelW);
                sbit_d  = ptr_q[BitSelW-1:0];
                state_d = B_READ;
              end
            end
            KIND_FREE: begin
              if (!ready_q) begin
                res_status_d = STS_NOT_READY;
              end else if (cmd_i.misaligned || cmd_i.beyond) begin
                res_status_d = STS_BAD_ADDR;
              end else begin
                state_d = B_READ;
              end
            end
            KIND_QUERY: begin
              if (cmd_i.beyond) begin
                res_used_d = 1'b1;
              end else begin
                state_d = B_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      B_MOD: begin
        // One remainder bit a cycle, most significant first.
        rem_d = mod_t;
        div_d = div_q - DivW'(1);
        if (div_q == '0) begin
          word_d  = AddrW'(mod_t >> BitSelW);
          sbit_d  = mod_t[BitSelW-1:0];
          state_d = B_READ;
        end
      end
      B_READ: begin
        state_d = B_CHECK;
      end
      B_CHECK: begin
        state_d = B_DONE;
        unique case (cmd_q.kind)
          KIND_RELEASE, KIND_RESERVE: begin
            if (cmd_q.kind == KIND_RELEASE) begin
              free_d = sat_add(free_q, cnt_rel);
              used_d = sat_sub(used_q, cnt_rel);
            end else begin
              free_d = sat_sub(free_q, cnt_res);
              used_d = sat_add(used_q, cnt_res);
            end
            if (!last_range_word) begin
              word_d  = word_q + AddrW'(1);
              state_d = B_READ;
            end
          end
          KIND_ALLOC: begin
            if (found) begin
              free_d     = sat_sub(free_q, (BitSelW+1)'(1));
              used_d     = sat_add(used_q, (BitSelW+1)'(1));
              ptr_d      = cand + FrameW'(1);
              res_addr_d = 32'(cand) << FrameShift;
            end else if (visit_q == nw) begin
              res_status_d = STS_NO_MEM;
            end else begin
              visit_d = visit_q + VisitW'(1);
              word_d  = (VisitW'(word_q) + VisitW'(1) == nw) ? '0 : word_q + AddrW'(1);
              state_d = B_READ;
            end
          end
          KIND_FREE: begin
            if ((owned_w & bit_sel) == '0) begin
              res_status_d = STS_NOT_ALLOC;
            end else begin
              if ((used_w & bit_sel) != '0) begin
                free_d = sat_add(free_q, (BitSelW+1)'(1));
                used_d = sat_sub(used_q, (BitSelW+1)'(1));
              end
              if (cmd_q.first < ptr_q) begin
                ptr_d = cmd_q.first;
              end
            end
          end
          KIND_QUERY: begin
            res_used_d = |(used_w & bit_sel);
          end
          default: begin
          end
        endcase
      end
      B_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Handshake, memory and output register controls.
  always_comb begin
    cmd_pop_o  = (state_q == B_IDLE) && cmd_valid_i;
    clear_rows = cmd_pop_o && (cmd_i.kind == KIND_BEGIN);
    rd_en      = (state_q == B_READ);
    load_out   = (state_q == B_DONE) && (!out_valid_q || out_ready_i);
    wr_en      = 1'b0;
    wr_used    = used_w;
    wr_owned   = owned_w;
    if (state_q == B_CHECK) begin
      unique case (cmd_q.kind)
        KIND_RELEASE: begin
          wr_en   = 1'b1;
          wr_used = used_w & ~range_mask;
        end
        KIND_RESERVE: begin
          wr_en   = 1'b1;
          wr_used = used_w | range_mask;
        end
        KIND_ALLOC: begin
          wr_en    = found;
          wr_used  = used_w | (free_bits & ~(free_bits - WordBits'(1)));
          wr_owned = owned_w | (free_bits & ~(free_bits - WordBits'(1)));
        end
        KIND_FREE: begin
          wr_en    = (owned_w & bit_sel) != '0;
          wr_used  = used_w & ~bit_sel;
          wr_owned = owned_w & ~bit_sel;
        end
        default: begin
        end
      endcase
    end
    out_valid_d = load_out || (out_valid_q && !out_ready_i);
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      free_q      <= '0;
      used_q      <= '0;
      ptr_q       <= '0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_q      <= free_d;
      used_q      <= used_d;
      ptr_q       <= ptr_d;
      ready_q     <= ready_d;
      out_valid_q <= out_valid_d;
      if (clear_rows) begin
        row_valid_q <= '0;
      end else if (wr_en) begin
        row_valid_q[word_q] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_q <= row_valid_q[word_q];
      end
    end
  end

  // Working payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    word_q       <= word_d;
    visit_q      <= visit_d;
    sbit_q       <= sbit_d;
    rem_q        <= rem_d;
    div_q        <= div_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    res_used_q   <= res_used_d;
    if (load_out) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
      out_used_q   <= res_used_q;
      out_free_q   <= free_q;
      out_usedc_q  <= used_q;
    end
  end

  // Bitmap memories: one read and one write port, registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      used_mem[word_q]  <= wr_used;
      owned_mem[word_q] <= wr_owned;
    end
    if (rd_en) begin
      used_rd_q  <= used_mem[word_q];
      owned_rd_q <= owned_mem[word_q];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = 3'(out_status_q);
  assign frame_address_o = out_addr_q;
  assign is_used_o       = out_used_q;
  assign free_count_o    = out_free_q;
  assign used_count_o    = out_usedc_q;

endmodule

// File: design/bfa_checker.sv
`include "bitmap_frame_allocator_core_macros.svh"

module bfa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [31:0] frame_address_o,
  input logic        is_used_o
);
  import bfa_pkg::*;

  // A result stays offered until it is taken.
  `BFA_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped")

  // Handed-out addresses are always frame aligned.
  `BFA_ASSERT(a_addr_align, out_valid_o |-> frame_address_o[11:0] == 12'd0, "unaligned frame")

  // An address is only reported by a successful allocate.
  `BFA_ASSERT(a_addr_ok, out_valid_o && frame_address_o != 32'd0 |-> status_o == STS_OK,
              "address with failing status")

  // A query never fails, so a used answer comes with an ok status.
  `BFA_ASSERT(a_used_ok, out_valid_o && is_used_o |-> status_o == STS_OK,
              "used flag with failing status")

endmodule

bind bitmap_frame_allocator_core bfa_checker u_bfa_checker (.*);

// File: bench/testbench.sv
module testbench;
  import bfa_pkg::*;

  localparam int unsigned NumFrames = 4096;
  localparam int unsigned StallLimit = 40000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] address;
    logic [32:0] range_length;
  } request_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [31:0]       frame_address;
    logic              is_used;
    logic [CountW-1:0] free_count;
    logic [CountW-1:0] used_count;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [2:0] kind_i = '0;
  logic [31:0] address_i = '0;
  logic [32:0] range_length_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0] status_o;
  logic [31:0] frame_address_o;
  logic is_used_o;
  logic [CountW-1:0] free_count_o;
  logic [CountW-1:0] used_count_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [FrameW-1:0] cfg_data_i = '0;

  bitmap_frame_allocator_core u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i, .address_i, .range_length_i,
    .out_valid_o, .out_ready_i, .status_o, .frame_address_o, .is_used_o,
    .free_count_o, .used_count_o, .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  // Clock with a period of 10.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Allocator shadow state.
  bit          used_bits [NumFrames];
  bit          owned_bits [NumFrames];
  int unsigned free_frames;
  int unsigned used_frames;
  int unsigned next_fit;
  bit          alloc_ready;
  int unsigned frame_total;

  request_t pending_requests[$];
  answer_t  expected_answers[$];
  int unsigned accepted_requests;
  int unsigned idle_cycles;
  bit failed;
  bit calm_phase;

  function automatic int unsigned tracked_frames();
    return (frame_total > NumFrames) ? NumFrames : frame_total;
  endfunction

  function automatic void mark_used(int unsigned f);
    if (f >= tracked_frames() || used_bits[f]) return;
    used_bits[f] = 1'b1;
    if (free_frames > 0) free_frames--;
    if (used_frames < 8191) used_frames++;
  endfunction

  function automatic void mark_free(int unsigned f);
    if (f >= tracked_frames() || !used_bits[f]) return;
    used_bits[f] = 1'b0;
    if (free_frames < 8191) free_frames++;
    if (used_frames > 0) used_frames--;
  endfunction

  // Work out the answer of the allocator to one request.
  function automatic answer_t allocator_answer(request_t r);
    answer_t a;
    int unsigned tot, fi, cand;
    longint unsigned first, last, stop;
    a = '0;
    tot = tracked_frames();
    stop = longint'(r.address) + longint'(r.range_length);
    case (kind_e'(r.kind))
      KIND_BEGIN: begin
        foreach (used_bits[i]) begin
          used_bits[i] = 1'b1;
          owned_bits[i] = 1'b0;
        end
        free_frames = 0;
        used_frames = tot;
        next_fit = 0;
        alloc_ready = 1'b0;
      end
      KIND_RELEASE, KIND_RESERVE: begin
        if (r.kind == KIND_RELEASE) begin
          first = (longint'(r.address) + 4095) >> 12;
          last = stop >> 12;
        end else begin
          first = longint'(r.address) >> 12;
          last = (stop + 4095) >> 12;
        end
        if (first < tot) begin
          if (last > tot) last = tot;
          for (longint unsigned f = first; f < last; f++) begin
            if (r.kind == KIND_RELEASE) mark_free(int'(f));
            else mark_used(int'(f));
          end
        end
      end
      KIND_FINISH: begin
        alloc_ready = (free_frames != 0);
        if (!alloc_ready) a.status = STS_NO_MEM;
      end
      KIND_ALLOC: begin
        if (!alloc_ready) begin
          a.status = STS_NOT_READY;
        end else begin
          a.status = STS_NO_MEM;
          for (int unsigned k = 0; k < tot; k++) begin
            cand = next_fit + k;
            if (cand >= tot) cand -= tot;
            if (cand >= tot) cand %= tot;
            if (!used_bits[cand]) begin
              mark_used(cand);
              owned_bits[cand] = 1'b1;
              a.frame_address = 32'(cand) << 12;
              next_fit = (cand + 1) & 32'h1fff;
              a.status = STS_OK;
              break;
            end
          end
        end
      end
      KIND_FREE: begin
        fi = r.address >> 12;
        if (!alloc_ready) a.status = STS_NOT_READY;
        else if (r.address[11:0] != 0 || fi >= tot) a.status = STS_BAD_ADDR;
        else if (!owned_bits[fi]) a.status = STS_NOT_ALLOC;
        else begin
          owned_bits[fi] = 1'b0;
          mark_free(fi);
          if (fi < next_fit) next_fit = fi;
        end
      end
      KIND_QUERY: begin
        fi = r.address >> 12;
        a.is_used = (fi >= tot) || used_bits[fi];
      end
      default: ;
    endcase
    a.free_count = CountW'(free_frames);
    a.used_count = CountW'(used_frames);
    return a;
  endfunction

  function automatic request_t make_request(kind_e k, logic [31:0] ad, logic [32:0] len);
    request_t r;
    r.kind = k;
    r.address = ad;
    r.range_length = len;
    return r;
  endfunction

  // A random request, mostly aimed at the tracked frames.
  function automatic request_t random_request();
    request_t r;
    int unsigned pick;
    pick = $urandom_range(99);
    r.address = (pick < 70) ? ($urandom_range(4200) << 12) : $urandom;
    if ($urandom_range(3) == 0) r.address[11:0] = 12'($urandom);
    r.range_length = ($urandom_range(7) == 0) ? 33'({$urandom, $urandom}) :
                     33'($urandom_range(40000));
    pick = $urandom_range(99);
    if (pick < 3) r.kind = KIND_BEGIN;
    else if (pick < 15) r.kind = KIND_RELEASE;
    else if (pick < 23) r.kind = KIND_RESERVE;
    else if (pick < 27) r.kind = KIND_FINISH;
    else if (pick < 60) r.kind = KIND_ALLOC;
    else if (pick < 80) r.kind = KIND_FREE;
    else if (pick < 98) r.kind = KIND_QUERY;
    else r.kind = KIND_NOP;
    // Frees mostly target a frame the allocator may own.
    if (r.kind == KIND_FREE && pick < 75) r.address = $urandom_range(tracked_frames()) << 12;
    return r;
  endfunction

  // Request driver.
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      expected_answers.push_back(allocator_answer({kind_i, address_i, range_length_i}));
      accepted_requests <= accepted_requests + 1;
    end
    if (!in_valid_i || in_ready_o) begin
      if (pending_requests.size() > 0 && rst_ni &&
          (calm_phase || $urandom_range(99) >= 12)) begin
        request_t r;
        r = pending_requests.pop_front();
        in_valid_i <= 1'b1;
        {kind_i, address_i, range_length_i} <= r;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (expected_answers.size() == 0) begin
        $error("unexpected item: status %0d", status_o);
        failed = 1'b1;
      end else begin
        answer_t e;
        e = expected_answers.pop_front();
        if (status_o !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status_o);
          failed = 1'b1;
        end
        if (frame_address_o !== e.frame_address) begin
          $error("frame_address: expected %h, got %h", e.frame_address, frame_address_o);
          failed = 1'b1;
        end
        if (is_used_o !== e.is_used) begin
          $error("is_used: expected %0d, got %0d", e.is_used, is_used_o);
          failed = 1'b1;
        end
        if (free_count_o !== e.free_count) begin
          $error("free_count: expected %0d, got %0d", e.free_count, free_count_o);
          failed = 1'b1;
        end
        if (used_count_o !== e.used_count) begin
          $error("used_count: expected %0d, got %0d", e.used_count, used_count_o);
          failed = 1'b1;
        end
      end
    end
    out_ready_i <= calm_phase || ($urandom_range(99) >= 12);
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Write the frame count once the block has drained.
  task automatic write_total(int unsigned value);
    wait (pending_requests.size() == 0 && !in_valid_i && expected_answers.size() == 0);
    repeat (20) @(posedge clk_i);
    frame_total = value & 32'h1fff;
    cfg_data_i <= FrameW'(value);
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Queue a setup sequence followed by random traffic.
  task automatic queue_phase(int unsigned count);
    pending_requests.push_back(make_request(KIND_BEGIN, 0, 0));
    pending_requests.push_back(make_request(KIND_RELEASE, 0, 33'h1_0000_0000));
    pending_requests.push_back(make_request(KIND_RESERVE, 32'h0, 33'd1048576));
    pending_requests.push_back(make_request(KIND_RESERVE, 32'h0020_0800, 33'd5000));
    pending_requests.push_back(make_request(KIND_FINISH, 0, 0));
    for (int unsigned i = 0; i < count; i++) pending_requests.push_back(random_request());
  endtask

  initial begin
    frame_total = 4096;
    alloc_ready = 1'b0;
    free_frames = 0;
    used_frames = 0;
    next_fit = 0;
    foreach (used_bits[i]) begin
      used_bits[i] = 1'b1;
      owned_bits[i] = 1'b0;
    end
    calm_phase = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: operations before begin, extremes of every field.
    pending_requests.push_back(make_request(KIND_ALLOC, 0, 0));
    pending_requests.push_back(make_request(KIND_FREE, 32'h1000, 0));
    pending_requests.push_back(make_request(KIND_QUERY, 32'hffff_ffff, 0));
    pending_requests.push_back(make_request(KIND_FINISH, 0, 0));
    pending_requests.push_back(make_request(KIND_NOP, 32'hffff_ffff, 33'h1_ffff_ffff));
    pending_requests.push_back(make_request(KIND_BEGIN, 0, 0));
    pending_requests.push_back(make_request(KIND_FINISH, 0, 0));
    pending_requests.push_back(make_request(KIND_RELEASE, 32'hffff_ffff, 33'h1_ffff_ffff));
    pending_requests.push_back(make_request(KIND_RELEASE, 32'h0000_0001, 33'h0000_2fff));
    pending_requests.push_back(make_request(KIND_RELEASE, 32'h00ff_f000, 33'h1_0000_0000));
    pending_requests.push_back(make_request(KIND_FINISH, 0, 0));
    pending_requests.push_back(make_request(KIND_ALLOC, 0, 0));
    pending_requests.push_back(make_request(KIND_ALLOC, 0, 0));
    pending_requests.push_back(make_request(KIND_FREE, 32'h0000_1001, 0));
    pending_requests.push_back(make_request(KIND_FREE, 32'hffff_f000, 0));
    pending_requests.push_back(make_request(KIND_FREE, 32'h0000_0000, 0));
    pending_requests.push_back(make_request(KIND_FREE, 32'h0000_1000, 0));
    pending_requests.push_back(make_request(KIND_QUERY, 32'h0000_1fff, 0));
    pending_requests.push_back(make_request(KIND_QUERY, 32'h00ff_ffff, 0));
    pending_requests.push_back(make_request(KIND_RESERVE, 32'h00ff_ffff, 33'd1));
    pending_requests.push_back(make_request(KIND_RESERVE, 32'hffff_ffff, 33'h1_ffff_ffff));
    queue_phase(150);

    write_total(1);
    queue_phase(120);
    write_total(0);
    queue_phase(40);
    write_total(8191);
    calm_phase = 1'b1;
    queue_phase(200);
    write_total(37);
    calm_phase = 1'b0;
    queue_phase(240);
    write_total(4096);
    queue_phase(250);

    wait (pending_requests.size() == 0 && !in_valid_i && expected_answers.size() == 0);
    repeat (200) @(posedge clk_i);
    if (!failed && expected_answers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
